[hw/rtl/zcwe_pkg.sv]
// Shared types and constants for the zero-crossing wave extractor.
package zcwe_pkg;

	localparam int unsigned TIME_W = 32;
	// sample times are used as plain integers, so the fraction width changes no result
	localparam int unsigned TIME_FRAC_BITS = 16;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_NT   = 5'b00010,
		ST_VR   = 5'b00100,
		ST_HR   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		DSEL_NT = 2'd0,
		DSEL_VR = 2'd1,
		DSEL_HR = 2'd2
	} dsel_t;

	typedef struct packed {
		logic  capture;
		logic  div_start;
		dsel_t div_sel;
		logic  commit;
		logic  out_load;
	} zcwe_cmd_t;

	typedef struct packed {
		logic crossing;
		logic emit;
		logic div_done;
	} zcwe_sts_t;

endpackage

[hw/rtl/zcwe_div.sv]
// Restoring divider, one quotient bit per cycle.
module zcwe_div #(
	parameter int unsigned N_W = 64,
	parameter int unsigned D_W = 33
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo
);
	localparam int unsigned CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0] quo_q;
	logic [D_W:0] rem_q;
	logic [D_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [D_W:0] rem_sh;
	logic [D_W:0] rem_sub;

	assign rem_sh = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!rem_sub[D_W]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[N_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

[hw/rtl/zcwe_datapath.sv]
// Datapath: sample history, half-wave peaks, null times, divider and result register.
module zcwe_datapath #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned RATIO_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  zcwe_pkg::zcwe_cmd_t          cmd,
	output zcwe_pkg::zcwe_sts_t          sts,
	input  logic [31:0]                  sample_time,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                         end_of_record,
	output logic                         crossing_kind,
	output logic [31:0]                  start_time,
	output logic [31:0]                  middle_time,
	output logic [31:0]                  end_time,
	output logic [SAMPLE_BITS-2:0]       crest_value,
	output logic [SAMPLE_BITS-1:0]       trough_depth,
	output logic [SAMPLE_BITS-1:0]       wave_height,
	output logic [31:0]                  crest_time,
	output logic [31:0]                  trough_time,
	output logic [15:0]                  vertical_ratio,
	output logic [15:0]                  horizontal_ratio
);
	import zcwe_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned MAG_W = SB + 1;
	localparam int unsigned NUM_W = (MAG_W > RATIO_FRAC_BITS) ? 33 + MAG_W
		: 33 + RATIO_FRAC_BITS;
	localparam int unsigned DEN_W = 33;

	logic [31:0] last_time_q, old_nt_q, rec_nt_q, t_q;
	logic signed [SB-1:0] last_value_q, v_q;
	logic have_last_q, eor_q;
	logic [1:0] seen_q;
	logic signed [SB-1:0] pmax_q, pmin_q, cmax_q, cmin_q;
	logic [31:0] pmax_t_q, pmin_t_q, cmax_t_q, cmin_t_q;
	logic [31:0] nt_q;
	logic [15:0] vr_q;

	logic [MAG_W-1:0] mag_a, mag_b;
	logic [32:0] delta;
	logic [32:0] delta_mag;
	logic [NUM_W-1:0] prod;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic div_done;
	logic [NUM_W-1:0] div_quo;
	logic [31:0] nt_new;

	logic signed [SB-1:0] crest_s, low_s;
	logic [31:0] crest_t, low_t;
	logic [SB-1:0] cv, td;
	logic signed [32:0] d1, d2;

	assign mag_a = last_value_q[SB-1] ? MAG_W'(-$signed({last_value_q[SB-1], last_value_q}))
		: MAG_W'({1'b0, last_value_q});
	assign mag_b = v_q[SB-1] ? MAG_W'(-$signed({v_q[SB-1], v_q})) : MAG_W'({1'b0, v_q});
	assign delta = {1'b0, t_q} - {1'b0, last_time_q};
	assign delta_mag = delta[32] ? -delta : delta;
	assign prod = NUM_W'(delta_mag) * NUM_W'(mag_a);
	assign nt_new = delta[32] ? last_time_q - div_quo[31:0] : last_time_q + div_quo[31:0];

	assign crest_s = (cmax_q > pmax_q) ? cmax_q : pmax_q;
	assign crest_t = (cmax_q > pmax_q) ? cmax_t_q : pmax_t_q;
	assign low_s = (cmin_q < pmin_q) ? cmin_q : pmin_q;
	assign low_t = (cmin_q < pmin_q) ? cmin_t_q : pmin_t_q;
	assign cv = crest_s;
	assign td = SB'(-low_s);
	assign d1 = $signed({1'b0, rec_nt_q}) - $signed({1'b0, old_nt_q});
	assign d2 = $signed({1'b0, nt_q}) - $signed({1'b0, rec_nt_q});

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (cmd.div_sel)
			DSEL_NT: begin
				div_num = prod;
				div_den = DEN_W'(mag_a) + DEN_W'(mag_b);
			end
			DSEL_VR: begin
				div_num = NUM_W'(cv) << RATIO_FRAC_BITS;
				div_den = DEN_W'(td);
			end
			DSEL_HR: begin
				div_num = NUM_W'(d1[31:0]) << RATIO_FRAC_BITS;
				div_den = DEN_W'(d2[31:0]);
			end
			default: ;
		endcase
	end

	zcwe_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	assign sts.crossing = have_last_q && ((last_value_q > 0 && v_q < 0) ||
		(last_value_q < 0 && v_q > 0));
	assign sts.emit = seen_q == 2'd2;
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q <= sample_time;
			v_q <= sample_value;
			eor_q <= end_of_record;
		end
		if (div_done && cmd.div_sel == DSEL_NT)
			nt_q <= nt_new;
		if (div_done && cmd.div_sel == DSEL_VR)
			vr_q <= (td == '0) ? 16'hFFFF : ((|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0]);
		if (cmd.out_load) begin
			crossing_kind <= !(last_value_q > 0);
			start_time <= old_nt_q;
			middle_time <= rec_nt_q;
			end_time <= nt_q;
			crest_value <= cv[SB-2:0];
			trough_depth <= td;
			wave_height <= cv + td;
			crest_time <= crest_t;
			trough_time <= low_t;
			vertical_ratio <= vr_q;
			if (d1 <= 0)
				horizontal_ratio <= 16'h0;
			else if (d2 <= 0)
				horizontal_ratio <= 16'hFFFF;
			else
				horizontal_ratio <= (|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0; last_value_q <= '0; have_last_q <= 1'b0; seen_q <= '0;
			old_nt_q <= '0; rec_nt_q <= '0;
			pmax_q <= '0; pmin_q <= '0; cmax_q <= '0; cmin_q <= '0;
			pmax_t_q <= '0; pmin_t_q <= '0; cmax_t_q <= '0; cmin_t_q <= '0;
		end else if (cmd.commit) begin
			if (eor_q) begin
				last_time_q <= '0; last_value_q <= '0; have_last_q <= 1'b0; seen_q <= '0;
				old_nt_q <= '0; rec_nt_q <= '0;
				pmax_q <= '0; pmin_q <= '0; cmax_q <= '0; cmin_q <= '0;
				pmax_t_q <= '0; pmin_t_q <= '0; cmax_t_q <= '0; cmin_t_q <= '0;
			end else begin
				last_time_q <= t_q;
				last_value_q <= v_q;
				have_last_q <= 1'b1;
				if (sts.crossing) begin
					old_nt_q <= rec_nt_q;
					// a commit while the null-time division signals done takes the fresh quotient
					rec_nt_q <= (div_done && cmd.div_sel == DSEL_NT) ? nt_new : nt_q;
					pmax_q <= cmax_q; pmax_t_q <= cmax_t_q;
					pmin_q <= cmin_q; pmin_t_q <= cmin_t_q;
					if (seen_q != 2'd2) seen_q <= seen_q + 1'b1;
					cmax_q <= (v_q > 0) ? v_q : '0;
					cmax_t_q <= (v_q > 0) ? t_q : '0;
					cmin_q <= (v_q < 0) ? v_q : '0;
					cmin_t_q <= (v_q < 0) ? t_q : '0;
				end else begin
					if (v_q > cmax_q) begin cmax_q <= v_q; cmax_t_q <= t_q; end
					if (v_q < cmin_q) begin cmin_q <= v_q; cmin_t_q <= t_q; end
				end
			end
		end
	end
endmodule

[hw/rtl/zcwe_ctrl.sv]
// Control state machine sequencing capture, divisions, commit and output.
module zcwe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  zcwe_pkg::zcwe_sts_t sts,
	output zcwe_pkg::zcwe_cmd_t cmd
);
	import zcwe_pkg::*;

	state_t state_q;
	dsel_t sel_q;
	logic go_q;
	logic outv_q;

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = outv_q;

	always_comb begin
		cmd = '0;
		cmd.capture = in_fire;
		cmd.div_sel = sel_q;
		cmd.div_start = go_q;
		case (state_q)
			ST_NT: cmd.commit = !go_q && (!sts.crossing || (sts.div_done && !sts.emit));
			ST_HR: begin
				cmd.out_load = sts.div_done;
				cmd.commit = sts.div_done;
			end
			ST_VR: ;
			ST_IDLE: ;
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= DSEL_NT;
			go_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (outv_q && out_ready) outv_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_fire) begin
					state_q <= ST_NT;
					sel_q <= DSEL_NT;
					go_q <= 1'b1;
				end
				ST_NT: if (!go_q) begin
					if (!sts.crossing) state_q <= ST_IDLE;
					else if (sts.div_done) begin
						if (sts.emit) begin
							state_q <= ST_VR;
							sel_q <= DSEL_VR;
							go_q <= 1'b1;
						end else state_q <= ST_IDLE;
					end
				end
				ST_VR: if (sts.div_done) begin
					state_q <= ST_OUT;
					sel_q <= DSEL_HR;
				end
				ST_OUT: if (!outv_q || out_ready) begin
					state_q <= ST_HR;
					go_q <= 1'b1;
				end
				ST_HR: if (sts.div_done) begin
					outv_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hw/rtl/zero_crossing_wave_extractor.sv]
// Top level of the zero-crossing wave extractor.
// One sample per beat. A sample without a crossing does not wait for a division; a crossing
// takes one 50-step division for the null time, and a closing crossing two more (crest/trough
// ratio and half-period ratio), all run on the single shared bit-serial divider. The
// result sits in an output register, so the next sample is taken while a wave waits,
// but a following closing crossing holds until the earlier result has been taken.
module zero_crossing_wave_extractor #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned RATIO_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   sample_time,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                          end_of_record,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          crossing_kind,
	output logic [31:0]                   start_time,
	output logic [31:0]                   middle_time,
	output logic [31:0]                   end_time,
	output logic [SAMPLE_BITS-2:0]        crest_value,
	output logic [SAMPLE_BITS-1:0]        trough_depth,
	output logic [SAMPLE_BITS-1:0]        wave_height,
	output logic [31:0]                   crest_time,
	output logic [31:0]                   trough_time,
	output logic [15:0]                   vertical_ratio,
	output logic [15:0]                   horizontal_ratio
);
	import zcwe_pkg::*;

	zcwe_cmd_t cmd;
	zcwe_sts_t sts;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	zcwe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	zcwe_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.sample_time(sample_time), .sample_value(sample_value),
		.end_of_record(end_of_record),
		.crossing_kind(crossing_kind), .start_time(start_time),
		.middle_time(middle_time), .end_time(end_time), .crest_value(crest_value),
		.trough_depth(trough_depth), .wave_height(wave_height),
		.crest_time(crest_time), .trough_time(trough_time),
		.vertical_ratio(vertical_ratio), .horizontal_ratio(horizontal_ratio)
	);

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result overwritten");
	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("beat taken while busy");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("double commit");
endmodule
